/* src/tiny_8bit_cpu_execute_macros.svh */
// ----------------------------------------------------------------------------
// tiny 8-bit cpu execute - assertion macros
// shared property wrappers, clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef TINY_8BIT_CPU_EXECUTE_MACROS_SVH
`define TINY_8BIT_CPU_EXECUTE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TCE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define TCE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// types and constants of the tiny 8-bit cpu execute block
// ----------------------------------------------------------------------------
package tce_pkg;

  localparam int unsigned AddrBitsDef = 16;
  localparam logic [7:0] ByteMax = 8'd255;

  typedef enum logic [3:0] {
    OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_OR,  OP_AND,
    OP_MVI, OP_ADI, OP_SUI, OP_MUI, OP_ORI, OP_ANI,
    OP_INC, OP_DEC, OP_LDA, OP_STA
  } tce_op_e;

  typedef enum logic [2:0] {
    ALU_MOV, ALU_ADD, ALU_SUB, ALU_MUL, ALU_OR, ALU_AND
  } tce_alu_e;

  typedef enum logic [1:0] {
    REG_A, REG_B, REG_C, REG_D
  } tce_reg_e;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [1:0]  dest_sel;
    logic [1:0]  src_sel;
    logic [7:0]  imm_byte;
    logic [15:0] mem_addr;
  } tce_in_t;

  typedef struct packed {
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic [7:0] out_c;
    logic [7:0] out_d;
    logic       carry_flag;
    logic       zero_flag;
  } tce_out_t;

endpackage

/* src/tiny_8bit_cpu_execute.sv */
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_execute
// execute stage: four 8-bit registers, carry and zero flags, byte data memory
// ----------------------------------------------------------------------------
// One decoded instruction is taken per beat and one result beat, holding all
// four registers and both flags after the instruction, comes out per input.
// Sustained rate is one instruction per cycle while the output is not stalled;
// a beat is registered in the execute stage with the synchronous data memory
// read (issued when taken, used when it executes), then its result in the
// state register. A store directly ahead of a load to the same address is
// forwarded. After reset the data memory is cleared one byte a cycle, and no
// beat is taken until its 2**ADDR_BITS bytes (65536 by default) are clear.
module tiny_8bit_cpu_execute #(
  parameter int unsigned ADDR_BITS = tce_pkg::AddrBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tce_pkg::tce_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tce_pkg::tce_out_t out_o
);
  import tce_pkg::*;

  localparam int unsigned MemDepth = 1 << ADDR_BITS;

  // clearing pass
  logic                 clr_busy_q, clr_busy_d;
  logic [ADDR_BITS-1:0] clr_addr_q, clr_addr_d;

  // execute stage holding register
  logic    s1_valid_q, s1_valid_d;
  tce_in_t s1_q;

  // architectural state, doubles as the result register
  tce_out_t state_q, state_d;
  logic     out_valid_q, out_valid_d;

  // memory
  logic [7:0]           mem_q [MemDepth];
  logic [7:0]           rdata_q;
  logic                 fwd_q;
  logic [7:0]           fwd_data_q;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 mem_re;
  logic [ADDR_BITS-1:0] mem_raddr;

  logic       exec;
  logic       sta_we;
  logic [7:0] load_data;

  // execute datapath
  tce_op_e    op;
  tce_alu_e   alu;
  logic [7:0] regs_v [4];
  logic [7:0] res_regs [4];
  logic [1:0] dsel;
  logic [7:0] dval;
  logic [7:0] opnd;
  logic [8:0] sum;
  logic [15:0] prod;
  logic [7:0] res;
  logic       res_c;

  assign exec       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_busy_q && (!s1_valid_q || exec);
  assign mem_re     = in_valid_i && in_ready_o;
  assign mem_raddr  = in_i.mem_addr[ADDR_BITS-1:0];
  assign load_data  = fwd_q ? fwd_data_q : rdata_q;

  assign out_valid_o = out_valid_q;
  assign out_o       = state_q;

  assign regs_v[REG_A] = state_q.out_a;
  assign regs_v[REG_B] = state_q.out_b;
  assign regs_v[REG_C] = state_q.out_c;
  assign regs_v[REG_D] = state_q.out_d;

  always_comb begin
    op       = tce_op_e'(s1_q.req_type);
    dsel     = s1_q.dest_sel;
    dval     = regs_v[dsel];
    opnd     = regs_v[s1_q.src_sel];
    alu      = ALU_MOV;
    state_d  = state_q;
    sta_we   = 1'b0;
    res_regs = regs_v;
    res      = '0;
    res_c    = 1'b0;
    sum      = '0;
    prod     = '0;

    if (op inside {[OP_MOV:OP_AND]}) begin
      alu = tce_alu_e'(op[2:0]);
    end else if (op inside {[OP_MVI:OP_ANI]}) begin
      alu  = tce_alu_e'(3'(op - OP_MVI));
      opnd = s1_q.imm_byte;
    end else if (op == OP_INC) begin
      alu  = ALU_ADD;
      opnd = 8'd1;
    end

    if (op inside {[OP_MOV:OP_INC]}) begin
      case (alu)
        ALU_MOV: res = opnd;
        ALU_ADD: begin
          sum   = {1'b0, dval} + {1'b0, opnd};
          res   = sum[7:0];
          res_c = sum[8];
        end
        ALU_SUB: res = dval - opnd;
        ALU_MUL: begin
          prod  = 16'(dval) * 16'(opnd);
          res   = prod[7:0];
          res_c = |prod[15:8];
        end
        ALU_OR:  res = dval | opnd;
        ALU_AND: res = dval & opnd;
        default: res = opnd;
      endcase
      // subtract of zero leaves register and flags as they are
      if (!(alu == ALU_SUB && opnd == '0)) begin
        res_regs[dsel]     = res;
        state_d.carry_flag = res_c;
        state_d.zero_flag  = (res == '0);
      end
    end else if (op == OP_DEC) begin
      res                = dval - 8'd1;
      res_regs[dsel]     = res;
      state_d.carry_flag = 1'b0;
      state_d.zero_flag  = (res == '0);
    end else if (op == OP_LDA) begin
      res_regs[REG_A]    = load_data;
      state_d.carry_flag = 1'b0;
      state_d.zero_flag  = (load_data == '0);
    end else begin
      sta_we = 1'b1;
    end

    state_d.out_a = res_regs[REG_A];
    state_d.out_b = res_regs[REG_B];
    state_d.out_c = res_regs[REG_C];
    state_d.out_d = res_regs[REG_D];
  end

  // single write port shared by the clearing pass and stores
  always_comb begin
    mem_we    = clr_busy_q || (exec && sta_we);
    mem_waddr = clr_busy_q ? clr_addr_q : s1_q.mem_addr[ADDR_BITS-1:0];
    mem_wdata = clr_busy_q ? 8'd0 : state_q.out_a;
  end

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_BITS'(1);
      if (&clr_addr_q) begin
        clr_busy_d = 1'b0;
      end
    end
    s1_valid_d = mem_re || (s1_valid_q && !exec);
    out_valid_d = exec || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (exec) begin
        state_q <= state_d;
      end
    end
  end

  // beat payload and store-to-load forward capture
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_q       <= in_i;
      fwd_q      <= mem_we && (mem_waddr == mem_raddr);
      fwd_data_q <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

`include "tiny_8bit_cpu_execute_macros.svh"

  `TCE_ASSERT_NEXT(a_clr_done_sticks, !clr_busy_q, !clr_busy_q, "clearing pass restarted")
  `TCE_ASSERT_NOW(a_clr_writes_zero, clr_busy_q, mem_we && mem_wdata == 8'd0,
                  "clearing pass not writing zero")
  `TCE_ASSERT_NEXT(a_sta_keeps_state, exec && sta_we, state_q == $past(state_q),
                   "store changed registers or flags")
  `TCE_ASSERT_NEXT(a_fwd_capture, mem_re && mem_we && mem_waddr == mem_raddr,
                   fwd_q && fwd_data_q == $past(mem_wdata), "store forward missed")

endmodule
